// ===== src/prc_pkg.sv =====
package prc_pkg;

  // word and internal formats
  localparam int DATA_WIDTH      = 32;
  localparam int ROTATION_STAGES = 28;
  localparam int IW              = 64;
  localparam int HALF_W          = IW / 2;
  localparam int GUARD           = 59 - DATA_WIDTH;
  localparam int ANG_SHIFT       = 63 - DATA_WIDTH;
  localparam int STAGE_W         = $clog2(ROTATION_STAGES);
  localparam int SCALE_LAT       = 6;

  // request types
  localparam logic MODE_TO_CYL = 1'b0;
  localparam logic MODE_TO_SPH = 1'b1;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic signed [IW-1:0]         wide_t;

  typedef struct packed {
    wide_t x;
    wide_t y;
    wide_t z;
  } rot_t;

  typedef struct packed {
    logic  mode;
    logic  hzero;
    word_t spec_len;
    word_t spec_ang;
  } side_t;

  typedef wide_t atan_tab_t [ROTATION_STAGES];

  localparam wide_t PI_Q60      = 64'sh3243F6A8885A308D;
  localparam wide_t HALF_PI_Q60 = PI_Q60 >>> 1;
  localparam wide_t ANG_RND     = 64'sd1 <<< (ANG_SHIFT - 1);
  localparam wide_t LEN_RND     = 64'sd1 <<< (GUARD - 1);
  localparam wide_t HP_ANG      = (HALF_PI_Q60 + ANG_RND) >>> ANG_SHIFT;
  localparam wide_t WORD_MAX    = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam wide_t WORD_MIN    = -(64'sd1 <<< (DATA_WIDTH - 1));
  localparam word_t HP_W        = word_t'(HP_ANG);

  // restoring division, elaboration only
  function automatic logic [IW-1:0] udiv64(input logic [IW-1:0] num,
                                           input logic [IW-1:0] den);
    logic [IW:0]   rem;
    logic [IW-1:0] q;
    rem = '0;
    q   = '0;
    for (int b = IW - 1; b >= 0; b--) begin
      rem = {rem[IW-1:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // (a*b) >> s, truncated to 64 bits, elaboration only
  function automatic logic [IW-1:0] mulsh(input logic [IW-1:0] a,
                                          input logic [IW-1:0] b,
                                          input int s);
    logic [2*IW-1:0] prod;
    logic [2*IW-1:0] sh;
    prod = {{IW{1'b0}}, a} * {{IW{1'b0}}, b};
    sh   = prod >> s;
    return sh[IW-1:0];
  endfunction

  // inverse cordic gain in Q62
  function automatic logic [IW-1:0] inv_gain_k();
    logic [IW-1:0] p;
    logic [IW-1:0] k;
    logic [IW-1:0] cand;
    logic [IW-1:0] t;
    p = 64'd1 << 60;
    k = '0;
    for (int i = 0; i < ROTATION_STAGES; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    for (int b = 61; b >= 0; b--) begin
      cand = k | (64'd1 << b);
      t    = mulsh(cand, cand, 62);
      if (mulsh(t, p, 60) <= (64'd1 << 62)) k = cand;
    end
    return k;
  endfunction

  // atan(2^-i) in Q60 from the truncated series
  function automatic atan_tab_t build_atan();
    atan_tab_t     tab;
    logic [IW-1:0] s;
    logic [IW-1:0] term;
    int            e;
    for (int i = 0; i < ROTATION_STAGES; i++) begin
      if (i == 0) begin
        tab[i] = PI_Q60 >>> 2;
      end else begin
        s = '0;
        for (int k = 0; k < 32; k++) begin
          if (i * (2 * k + 1) <= 62) begin
            e    = 62 - i * (2 * k + 1);
            term = udiv64(64'd1 << e, 64'(2 * k + 1));
            if (k % 2 == 1) s = s - term;
            else s = s + term;
          end
        end
        tab[i] = wide_t'((s + 64'd2) >> 2);
      end
    end
    return tab;
  endfunction

  localparam atan_tab_t     ATAN_TAB = build_atan();
  localparam logic [IW-1:0] INV_GAIN = inv_gain_k();

  function automatic word_t sat_word(input wide_t v);
    word_t res;
    if (v > WORD_MAX) res = word_t'(WORD_MAX);
    else if (v < WORD_MIN) res = word_t'(WORD_MIN);
    else res = word_t'(v);
    return res;
  endfunction

endpackage

// ===== src/prc_if.sv =====
interface prc_in_if;
  import prc_pkg::*;

  logic  valid;
  logic  ready;
  logic  req_type;
  word_t first_operand;
  word_t second_operand;

  modport source (output valid, req_type, first_operand, second_operand, input ready);
  modport sink   (input valid, req_type, first_operand, second_operand, output ready);
endinterface

interface prc_out_if;
  import prc_pkg::*;

  logic  valid;
  logic  ready;
  word_t first_result;
  word_t second_result;

  modport source (output valid, first_result, second_result, input ready);
  modport sink   (input valid, first_result, second_result, output ready);
endinterface

// ===== src/prc_rot_cell.sv =====
module prc_rot_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [prc_pkg::STAGE_W-1:0]  stage_idx,
  input  logic                         vld_i,
  input  prc_pkg::rot_t                rot_i,
  input  prc_pkg::side_t               side_i,
  output logic                         vld_o,
  output prc_pkg::rot_t                rot_o,
  output prc_pkg::side_t               side_o
);
  import prc_pkg::*;

  logic  vld_r;
  rot_t  rot_r;
  rot_t  rot_nxt;
  side_t side_r;
  wide_t dx;
  wide_t dy;
  wide_t t;
  logic  ccw;

  assign dx = $signed(rot_i.y) >>> stage_idx;
  assign dy = $signed(rot_i.x) >>> stage_idx;
  assign t  = ATAN_TAB[stage_idx];

  // rotation follows the angle, vectoring drives y to zero
  assign ccw = (side_i.mode == MODE_TO_CYL) ? ~rot_i.z[IW-1] : rot_i.y[IW-1];

  always_comb begin
    if (ccw) begin
      rot_nxt.x = $signed(rot_i.x) - dx;
      rot_nxt.y = $signed(rot_i.y) + dy;
      rot_nxt.z = $signed(rot_i.z) - t;
    end else begin
      rot_nxt.x = $signed(rot_i.x) + dx;
      rot_nxt.y = $signed(rot_i.y) - dy;
      rot_nxt.z = $signed(rot_i.z) + t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r  <= rot_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rot_o  = rot_r;
  assign side_o = side_r;

endmodule

// ===== src/prc_scale.sv =====
module prc_scale (
  input  logic           clk,
  input  logic           en,
  input  prc_pkg::wide_t val_i,
  output prc_pkg::word_t res_o
);
  import prc_pkg::*;

  localparam logic [HALF_W-1:0] K_LO = INV_GAIN[HALF_W-1:0];
  localparam logic [HALF_W-1:0] K_HI = INV_GAIN[IW-1:HALF_W];

  logic          neg0_r, neg1_r, neg2_r, neg3_r;
  logic [IW-1:0] mag_r;
  logic [IW-1:0] mag_nxt;
  logic [IW-1:0] p00_r, p01_r, p10_r, p11_r;
  logic [HALF_W+1:0] mid_r;
  logic [IW-1:0] hip_r;
  logic [IW-1:0] hi;
  logic [IW-1:0] mag2_r;
  wide_t         sv_r;
  wide_t         rnd;
  word_t         res_r;

  assign mag_nxt = val_i[IW-1] ? IW'(-val_i) : IW'(val_i);
  assign hi      = hip_r + IW'(mid_r[HALF_W+1:HALF_W]);
  assign rnd     = (sv_r + LEN_RND) >>> GUARD;

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitude
      neg0_r <= val_i[IW-1];
      mag_r  <= mag_nxt;
      // partial products
      neg1_r <= neg0_r;
      p00_r  <= IW'(mag_r[HALF_W-1:0])  * IW'(K_LO);
      p01_r  <= IW'(mag_r[HALF_W-1:0])  * IW'(K_HI);
      p10_r  <= IW'(mag_r[IW-1:HALF_W]) * IW'(K_LO);
      p11_r  <= IW'(mag_r[IW-1:HALF_W]) * IW'(K_HI);
      // column sums
      neg2_r <= neg1_r;
      mid_r  <= (HALF_W+2)'(p00_r[IW-1:HALF_W]) + (HALF_W+2)'(p01_r[HALF_W-1:0])
              + (HALF_W+2)'(p10_r[HALF_W-1:0]);
      hip_r  <= p11_r + IW'(p01_r[IW-1:HALF_W]) + IW'(p10_r[IW-1:HALF_W]);
      // product >> 62
      neg3_r <= neg2_r;
      mag2_r <= {hi[IW-3:0], mid_r[HALF_W-1:HALF_W-2]};
      // sign back
      sv_r   <= neg3_r ? -$signed(mag2_r) : $signed(mag2_r);
      // round to word and saturate
      res_r  <= sat_word(rnd);
    end
  end

  assign res_o = res_r;

endmodule

// ===== src/polar_rectangular_converter_unit.sv =====
// Polar/rectangular converter. Each beat carries a request type and two operands.
// Type 0 takes a radius and an angle and returns rho*sin(phi) and rho*cos(phi);
// type 1 takes r and h and returns the saturated length sqrt(r*r+h*h) and
// atan(r/h) in [-pi/2, pi/2]. Lengths are signed Q16.16, angles signed radians
// with 29 fraction bits. One beat is taken every cycle while results drain; a
// beat passes through 1 prep stage, one cell per micro-rotation for 28 cells,
// 6 gain-correction stages and 1 output stage. A one-beat input buffer holds a
// beat that arrives while the output is stalled, so ready drops only after a
// stall.
module polar_rectangular_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  prc_in_if.sink      in_ch,
  prc_out_if.source   out_ch
);
  import prc_pkg::*;

  localparam int N = ROTATION_STAGES;

  // pipeline advance: the whole chain moves unless the result is stuck
  logic en;
  logic in_fire;

  // input buffer
  logic  skid_full_r;
  logic  skid_type_r;
  word_t skid_a_r;
  word_t skid_b_r;

  logic  head_vld;
  logic  head_type;
  word_t head_a;
  word_t head_b;

  // prep stage
  wide_t a_w, b_w, a_sh, b_sh, z_in, a_abs;
  rot_t  rot_p_nxt;
  side_t side_p_nxt;
  logic  vld_p_r;
  rot_t  rot_p_r;
  side_t side_p_r;

  // cell chain taps
  logic  vld_c  [N+1];
  rot_t  rot_c  [N+1];
  side_t side_c [N+1];

  // gain correction and delay line
  word_t len_x;
  word_t len_y;
  wide_t zr;
  word_t ang_nxt;
  logic  dl_vld_r  [SCALE_LAT];
  side_t dl_side_r [SCALE_LAT];
  word_t dl_ang_r  [SCALE_LAT];

  // output register
  logic  out_valid_r;
  word_t out_first_r;
  word_t out_second_r;
  word_t first_nxt;
  word_t second_nxt;

  assign en          = ~out_valid_r | out_ch.ready;
  assign in_ch.ready = ~skid_full_r;
  assign in_fire     = in_ch.valid & ~skid_full_r;

  // a buffered beat goes first
  assign head_vld  = skid_full_r | in_ch.valid;
  assign head_type = skid_full_r ? skid_type_r : in_ch.req_type;
  assign head_a    = skid_full_r ? skid_a_r : in_ch.first_operand;
  assign head_b    = skid_full_r ? skid_b_r : in_ch.second_operand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (en) begin
      skid_full_r <= 1'b0;
    end else if (in_fire) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_fire) begin
      skid_type_r <= in_ch.req_type;
      skid_a_r    <= in_ch.first_operand;
      skid_b_r    <= in_ch.second_operand;
    end
  end

  // operands scaled up to the internal formats
  assign a_w   = wide_t'(head_a);
  assign b_w   = wide_t'(head_b);
  assign a_sh  = a_w <<< GUARD;
  assign b_sh  = b_w <<< GUARD;
  assign z_in  = b_w <<< ANG_SHIFT;
  assign a_abs = a_w[IW-1] ? -a_w : a_w;

  always_comb begin
    rot_p_nxt.y = '0;
    if (head_type == MODE_TO_CYL) begin
      // fold angles beyond a quarter turn and flip the start vector
      if (z_in > HALF_PI_Q60) begin
        rot_p_nxt.x = -a_sh;
        rot_p_nxt.z = z_in - PI_Q60;
      end else if (z_in < -HALF_PI_Q60) begin
        rot_p_nxt.x = -a_sh;
        rot_p_nxt.z = z_in + PI_Q60;
      end else begin
        rot_p_nxt.x = a_sh;
        rot_p_nxt.z = z_in;
      end
    end else begin
      // negative height: turn the vector into the right half plane
      rot_p_nxt.x = head_b[DATA_WIDTH-1] ? -b_sh : b_sh;
      rot_p_nxt.y = head_b[DATA_WIDTH-1] ? -a_sh : a_sh;
      rot_p_nxt.z = '0;
    end
  end

  // zero height has a closed-form answer carried alongside
  always_comb begin
    side_p_nxt.mode     = head_type;
    side_p_nxt.hzero    = (head_b == '0);
    side_p_nxt.spec_len = sat_word(a_abs);
    if (head_a[DATA_WIDTH-1]) side_p_nxt.spec_ang = -HP_W;
    else if (head_a != '0) side_p_nxt.spec_ang = HP_W;
    else side_p_nxt.spec_ang = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p_r <= 1'b0;
    end else if (en) begin
      vld_p_r <= head_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_p_r  <= rot_p_nxt;
      side_p_r <= side_p_nxt;
    end
  end

  assign vld_c[0]  = vld_p_r;
  assign rot_c[0]  = rot_p_r;
  assign side_c[0] = side_p_r;

  // one micro-rotation per cell
  for (genvar g = 0; g < N; g++) begin : g_cell
    prc_rot_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .stage_idx (STAGE_W'(g)),
      .vld_i     (vld_c[g]),
      .rot_i     (rot_c[g]),
      .side_i    (side_c[g]),
      .vld_o     (vld_c[g+1]),
      .rot_o     (rot_c[g+1]),
      .side_o    (side_c[g+1])
    );
  end

  // gain correction on both lengths
  prc_scale u_scale_x (
    .clk   (clk),
    .en    (en),
    .val_i (rot_c[N].x),
    .res_o (len_x)
  );

  prc_scale u_scale_y (
    .clk   (clk),
    .en    (en),
    .val_i (rot_c[N].y),
    .res_o (len_y)
  );

  // angle rounded to the output format and kept within a quarter turn
  assign zr = ($signed(rot_c[N].z) + ANG_RND) >>> ANG_SHIFT;

  always_comb begin
    if (zr > HP_ANG) ang_nxt = HP_W;
    else if (zr < -HP_ANG) ang_nxt = -HP_W;
    else ang_nxt = word_t'(zr);
  end

  // sideband waits out the gain correction latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SCALE_LAT; i++) dl_vld_r[i] <= 1'b0;
    end else if (en) begin
      dl_vld_r[0] <= vld_c[N];
      for (int i = 1; i < SCALE_LAT; i++) dl_vld_r[i] <= dl_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_side_r[0] <= side_c[N];
      dl_ang_r[0]  <= ang_nxt;
      for (int i = 1; i < SCALE_LAT; i++) begin
        dl_side_r[i] <= dl_side_r[i-1];
        dl_ang_r[i]  <= dl_ang_r[i-1];
      end
    end
  end

  // result select
  always_comb begin
    if (dl_side_r[SCALE_LAT-1].mode == MODE_TO_CYL) begin
      first_nxt  = len_y;
      second_nxt = len_x;
    end else if (dl_side_r[SCALE_LAT-1].hzero) begin
      first_nxt  = dl_side_r[SCALE_LAT-1].spec_len;
      second_nxt = dl_side_r[SCALE_LAT-1].spec_ang;
    end else begin
      first_nxt  = len_x[DATA_WIDTH-1] ? '0 : len_x;
      second_nxt = dl_ang_r[SCALE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dl_vld_r[SCALE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_first_r  <= first_nxt;
      out_second_r <= second_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.first_result  = out_first_r;
  assign out_ch.second_result = out_second_r;

endmodule

// ===== src/prc_checker.sv =====
module prc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input prc_pkg::word_t out_first_result,
  input prc_pkg::word_t out_second_result
);
  import prc_pkg::*;

  // stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_first_result) && $stable(out_second_result))
    else $error("result beat changed while stalled");

  // input side only backs off after an output stall
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input ready low without an output stall");

  // buffered beat drains as soon as the output moves
  a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && out_ready |=> in_ready)
    else $error("input ready stuck low after output moved");

endmodule

bind polar_rectangular_converter_unit prc_checker u_prc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_first_result  (out_ch.first_result),
  .out_second_result (out_ch.second_result)
);

// ===== bench/tb_polar_rectangular_converter_unit.sv =====
`timescale 1ns / 1ps

module tb_polar_rectangular_converter_unit;
  import prc_pkg::word_t;
  import prc_pkg::DATA_WIDTH;
  import prc_pkg::ROTATION_STAGES;
  import prc_pkg::MODE_TO_CYL;
  import prc_pkg::MODE_TO_SPH;

  // internal formats: lengths scaled up by guard bits, angles in Q60
  localparam int GUARD_BITS  = 59 - DATA_WIDTH;
  localparam int ANG_BITS    = 63 - DATA_WIDTH;
  localparam int HOLD_CYCLES = 300;  // long output hold-off in the backpressure phase
  localparam int DRAIN_WAIT  = 80;   // pipeline is 36 deep, leave margin for strays

  typedef logic signed [63:0] q60_t;
  typedef logic [63:0]        u64_t;

  localparam q60_t ANGLE_PI_Q60 = 64'sh3243F6A8885A308D;

  typedef struct packed {
    logic  mode;
    word_t first;
    word_t second;
  } conv_req_t;

  typedef struct packed {
    word_t first;
    word_t second;
  } conv_res_t;

  typedef enum int {
    PH_DIRECTED,
    PH_BURST,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH_IDLE,
    PH_BACKPRESSURE
  } phase_t;

  logic clk;
  logic rst_n;

  prc_in_if  in_ch ();
  prc_out_if out_ch ();

  polar_rectangular_converter_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  conv_req_t pending_reqs [$];   // requests waiting to be offered
  conv_res_t expected_coords [$]; // predicted results, oldest first

  phase_t phase     = PH_DIRECTED;
  int     idle_pct  = 0;
  int     stall_pct = 0;
  int     hold_cnt  = 0;
  int     errors    = 0;

  // predictor tables
  q60_t  atan_q60 [ROTATION_STAGES];
  u64_t  inv_gain_q62;
  word_t half_pi_ang;

  // ---------------------------------------------------------------------------
  // fixed-point helpers for the predictor
  // ---------------------------------------------------------------------------

  // low 64 bits of (a*b) >> s
  function automatic u64_t mul_shr(u64_t a, u64_t b, int s);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return u64_t'(prod >> s);
  endfunction

  function automatic q60_t sat_len(q60_t v);
    q60_t hi;
    q60_t lo;
    hi = (q60_t'(1) <<< (DATA_WIDTH - 1)) - q60_t'(1);
    lo = -(q60_t'(1) <<< (DATA_WIDTH - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // drop guard bits with round half up, then clamp to the word range
  function automatic q60_t round_len(q60_t v);
    return sat_len((v + (q60_t'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS);
  endfunction

  // Q60 angle back to the word format, round half up
  function automatic q60_t round_angle(q60_t z);
    return (z + (q60_t'(1) <<< (ANG_BITS - 1))) >>> ANG_BITS;
  endfunction

  // multiply by the inverse cordic gain, magnitude truncated toward zero
  function automatic q60_t gain_fix(q60_t x);
    u64_t mag;
    q60_t r;
    mag = (x < 0) ? u64_t'(-x) : u64_t'(x);
    r   = q60_t'(mul_shr(mag, inv_gain_q62, 62));
    return (x < 0) ? -r : r;
  endfunction

  // ---------------------------------------------------------------------------
  // predictor: one request in, one coordinate pair out
  // ---------------------------------------------------------------------------
  function automatic conv_res_t convert_coords(conv_req_t rq);
    q60_t      a;
    q60_t      b;
    q60_t      x;
    q60_t      y;
    q60_t      z;
    q60_t      dx;
    q60_t      dy;
    q60_t      hp;
    q60_t      half_pi;
    q60_t      len_out;
    q60_t      ang_out;
    conv_res_t res;
    a       = q60_t'(rq.first);
    b       = q60_t'(rq.second);
    half_pi = ANGLE_PI_Q60 >>> 1;
    hp      = round_angle(half_pi);
    if (rq.mode == MODE_TO_CYL) begin
      // rotation mode: start on the x axis, rotate by phi
      x = a <<< GUARD_BITS;
      y = '0;
      z = b <<< ANG_BITS;
      // fold angles outside +-pi/2 by a half turn
      if (z > half_pi) begin
        z = z - ANGLE_PI_Q60;
        x = -x;
      end else if (z < -half_pi) begin
        z = z + ANGLE_PI_Q60;
        x = -x;
      end
      for (int i = 0; i < ROTATION_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - atan_q60[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + atan_q60[i];
        end
      end
      res.first  = word_t'(round_len(gain_fix(y)));
      res.second = word_t'(round_len(gain_fix(x)));
    end else if (b == 0) begin
      // zero height bypasses the rotator
      res.first = word_t'(sat_len((a < 0) ? -a : a));
      if (a > 0) res.second = word_t'(hp);
      else if (a < 0) res.second = word_t'(-hp);
      else res.second = '0;
    end else begin
      // vectoring mode on (h, r), mirrored into the right half plane
      x = b <<< GUARD_BITS;
      y = a <<< GUARD_BITS;
      if (b < 0) begin
        x = -x;
        y = -y;
      end
      z = '0;
      for (int i = 0; i < ROTATION_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + atan_q60[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - atan_q60[i];
        end
      end
      len_out = round_len(gain_fix(x));
      if (len_out < 0) len_out = '0;
      ang_out = round_angle(z);
      if (ang_out > hp) ang_out = hp;
      if (ang_out < -hp) ang_out = -hp;
      res.first  = word_t'(len_out);
      res.second = word_t'(ang_out);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_request(logic mode, word_t first, word_t second);
    conv_req_t rq;
    rq.mode   = mode;
    rq.first  = first;
    rq.second = second;
    pending_reqs.push_back(rq);
  endtask

  // random mix: full-range words, small values, mixed magnitudes,
  // zero heights and angles close to the fold points
  task automatic queue_random(int count);
    logic  mode;
    int    kind;
    word_t a;
    word_t b;
    for (int n = 0; n < count; n++) begin
      mode = 1'($urandom_range(1, 0));
      kind = $urandom_range(9, 0);
      a    = $urandom;
      b    = $urandom;
      case (kind)
        0: begin
          a = word_t'(int'($urandom_range(512, 0)) - 256);
          b = word_t'(int'($urandom_range(512, 0)) - 256);
        end
        1: begin
          mode = MODE_TO_SPH;
          b    = '0;
          if ($urandom_range(3, 0) == 0) a = a >>> $urandom_range(31, 0);
        end
        2: begin
          a = a >>> $urandom_range(24, 0);
          b = b >>> $urandom_range(24, 0);
        end
        3: begin
          mode = MODE_TO_CYL;
          b    = half_pi_ang + word_t'(int'($urandom_range(8, 0)) - 4);
          if ($urandom_range(1, 0)) b = -b;
        end
        default: ;
      endcase
      queue_request(mode, a, b);
    end
  endtask

  task automatic enter_phase(phase_t ph, int idle, int stall);
    phase     = ph;
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  // wait until every queued request has been taken by the block
  task automatic wait_sent();
    while (pending_reqs.size() != 0 || in_ch.valid) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued requests, predicts on every accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    conv_req_t taken;
    conv_req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.mode   = in_ch.req_type;
        taken.first  = in_ch.first_operand;
        taken.second = in_ch.second_operand;
        expected_coords.push_back(convert_coords(taken));
      end
      // a held beat stays put until it is taken
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
          nxt                  = pending_reqs.pop_front();
          in_ch.valid          <= 1'b1;
          in_ch.req_type       <= nxt.mode;
          in_ch.first_operand  <= nxt.first;
          in_ch.second_operand <= nxt.second;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side ready: random stalls, plus one long hold-off so the
  // pipeline fills and the input stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (phase == PH_BACKPRESSURE && hold_cnt < HOLD_CYCLES) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= hold_cnt + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: each result beat against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    conv_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_coords.size() == 0) begin
        $display("%0t: result beat with nothing expected, first %h second %h",
                 $time, out_ch.first_result, out_ch.second_result);
        errors = errors + 1;
      end else begin
        want = expected_coords.pop_front();
        if (out_ch.first_result !== want.first) begin
          $display("%0t: first_result mismatch, expected %h actual %h",
                   $time, want.first, out_ch.first_result);
          errors = errors + 1;
        end
        if (out_ch.second_result !== want.second) begin
          $display("%0t: second_result mismatch, expected %h actual %h",
                   $time, want.second, out_ch.second_result);
          errors = errors + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : run_phases
    u64_t series;
    u64_t term;
    u64_t p;
    u64_t cand;
    u64_t sq;
    int   e;

    // atan(2^-i): pi/4 first, then the truncated odd series in Q62
    atan_q60[0] = ANGLE_PI_Q60 >>> 2;
    for (int i = 1; i < ROTATION_STAGES; i++) begin
      series = '0;
      for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
        e    = 62 - i * (2 * k + 1);
        term = (u64_t'(1) << e) / u64_t'(2 * k + 1);
        if (k % 2 == 1) series = series - term;
        else series = series + term;
      end
      atan_q60[i] = q60_t'((series + 64'd2) >> 2);
    end

    // cordic gain squared, then the largest Q62 inverse that fits
    p = u64_t'(1) << 60;
    for (int i = 0; i < ROTATION_STAGES; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    inv_gain_q62 = '0;
    for (int bit_idx = 61; bit_idx >= 0; bit_idx--) begin
      cand = inv_gain_q62 | (u64_t'(1) << bit_idx);
      sq   = mul_shr(cand, cand, 62);
      if (mul_shr(sq, p, 60) <= (u64_t'(1) << 62)) inv_gain_q62 = cand;
    end

    half_pi_ang = word_t'(round_angle(ANGLE_PI_Q60 >>> 1));

    // all block inputs known from time zero
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.req_type       = MODE_TO_CYL;
    in_ch.first_operand  = '0;
    in_ch.second_operand = '0;
    out_ch.ready         = 1'b0;

    // directed: extremes, folds, zero height, negative height, clamps
    enter_phase(PH_DIRECTED, 0, 0);
    queue_request(MODE_TO_CYL, word_t'(32'h0001_0000), '0);
    queue_request(MODE_TO_CYL, word_t'(32'h7FFF_FFFF), '0);
    queue_request(MODE_TO_CYL, word_t'(32'h8000_0000), '0);
    queue_request(MODE_TO_CYL, word_t'(32'h0001_0000), half_pi_ang);
    queue_request(MODE_TO_CYL, word_t'(32'h0001_0000), half_pi_ang + 1);
    queue_request(MODE_TO_CYL, word_t'(32'h0001_0000), -half_pi_ang);
    queue_request(MODE_TO_CYL, word_t'(32'h0001_0000), -half_pi_ang - 1);
    queue_request(MODE_TO_CYL, word_t'(32'h7FFF_FFFF), word_t'(32'h7FFF_FFFF));
    queue_request(MODE_TO_CYL, word_t'(32'h8000_0000), word_t'(32'h8000_0000));
    queue_request(MODE_TO_CYL, '0, word_t'(32'h1234_5678));
    queue_request(MODE_TO_CYL, word_t'(32'h7FFF_FFFF), half_pi_ang);
    queue_request(MODE_TO_SPH, word_t'(32'h0001_0000), '0);
    queue_request(MODE_TO_SPH, word_t'(-32'sd65536), '0);
    queue_request(MODE_TO_SPH, '0, '0);
    queue_request(MODE_TO_SPH, word_t'(32'h8000_0000), '0);
    queue_request(MODE_TO_SPH, word_t'(32'h7FFF_FFFF), '0);
    queue_request(MODE_TO_SPH, word_t'(32'h0003_0000), word_t'(32'h0004_0000));
    queue_request(MODE_TO_SPH, word_t'(32'h0003_0000), word_t'(-32'sd262144));
    queue_request(MODE_TO_SPH, word_t'(-32'sd196608), word_t'(-32'sd262144));
    queue_request(MODE_TO_SPH, '0, word_t'(-32'sd65536));
    queue_request(MODE_TO_SPH, word_t'(32'h7FFF_FFFF), word_t'(32'sd1));
    queue_request(MODE_TO_SPH, word_t'(32'h8000_0000), word_t'(32'sd1));
    queue_request(MODE_TO_SPH, word_t'(32'h8000_0000), word_t'(32'h8000_0000));
    queue_request(MODE_TO_SPH, word_t'(32'h7FFF_FFFF), word_t'(32'h7FFF_FFFF));
    queue_request(MODE_TO_SPH, word_t'(32'sd1), word_t'(32'sd1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait_sent();

    // random phases with different idle patterns
    enter_phase(PH_BURST, 0, 0);
    queue_random(300);
    wait_sent();

    enter_phase(PH_SEND_IDLE, 81, 0);
    queue_random(250);
    wait_sent();

    enter_phase(PH_RECV_STALL, 0, 81);
    queue_random(250);
    wait_sent();

    enter_phase(PH_BOTH_IDLE, 33, 33);
    queue_random(250);
    wait_sent();

    // sender keeps offering while the result side holds off
    enter_phase(PH_BACKPRESSURE, 0, 0);
    queue_random(250);
    wait_sent();

    while (expected_coords.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("tb_polar_rectangular_converter_unit passed");
    end else begin
      $display("tb_polar_rectangular_converter_unit failed");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #400000;
    $display("tb_polar_rectangular_converter_unit failed");
    $finish;
  end

endmodule
